[rtl/obstacle_map_cell_classifier_macros.svh]
// ----------------------------------------------------------------------------
// Obstacle map cell classifier assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_MAP_CELL_CLASSIFIER_MACROS_SVH
`define OBSTACLE_MAP_CELL_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define OMC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omc assertion failed");
// Next-cycle implication, disabled during reset.
`define OMC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omc assertion failed");
`else
`define OMC_ASSERT_IMP(label, clk, rst, ante, cons)
`define OMC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/omc_pkg.sv]
// ----------------------------------------------------------------------------
// Obstacle map cell classifier package
// Types, codes and small helper functions shared by the classifier RTL.
// ----------------------------------------------------------------------------
package omc_pkg;

  localparam int COORD_W = 10;
  localparam int ENTRY_W = 4;
  localparam int CLASS_W = 3;
  localparam int CFG_IDX_W = 2;

  // Side of the start and target marker squares.
  localparam int MARK_SIDE = 20;

  // Opcodes of an input transaction.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Shape kinds.
  localparam logic KIND_RECT = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  // Result classes.
  localparam logic [CLASS_W-1:0] CLS_START = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_TARGET = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_BLOCKED = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_FREE = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_OUTSIDE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 2'd3;

  // Configuration reset values.
  localparam logic [COORD_W-1:0] START_X_RST = 10'd20;
  localparam logic [COORD_W-1:0] START_Y_RST = 10'd20;
  localparam logic [COORD_W-1:0] TARGET_X_RST = 10'd492;
  localparam logic [COORD_W-1:0] TARGET_Y_RST = 10'd492;

  typedef logic [COORD_W-1:0] coord_t;

  // One obstacle table entry as held in the memory.
  typedef struct packed {
    logic   kind;
    coord_t row;
    coord_t col;
    coord_t rad;
    coord_t srow;
    coord_t scol;
  } obst_entry_t;

  // Absolute difference of two coordinates.
  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    abs_diff = (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  // True when the point lies inside the marker square centred on (cr, cc).
  function automatic logic in_marker(input coord_t pr, input coord_t pc,
                                     input coord_t cr, input coord_t cc);
    logic [COORD_W:0] twice_r;
    logic [COORD_W:0] twice_c;
    twice_r = {abs_diff(pr, cr), 1'b0};
    twice_c = {abs_diff(pc, cc), 1'b0};
    in_marker = (twice_r < (COORD_W+1)'(MARK_SIDE)) &&
                (twice_c < (COORD_W+1)'(MARK_SIDE));
  endfunction

endpackage

[rtl/omc_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module omc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/obstacle_map_cell_classifier.sv]
// A write is stored at its accepting edge and the next transaction may follow.
// An off-map or marker-square query goes straight to the finish state. Any other
// query reads the N table entries (N = NUM_OBST capped at 16) one per cycle,
// then drains the pipeline before finishing. The result is registered from the
// finish state once the output register is free, and the input reopens there.
// Reset: synchronous; entries read as empty via valid flags, markers (20,20), (492,492).
// ----------------------------------------------------------------------------
// Obstacle map cell classifier
// Holds a table of circle and rectangle obstacles and classifies grid points
// as start, target, blocked, free or outside the map.
// ----------------------------------------------------------------------------
`include "obstacle_map_cell_classifier_macros.svh"

module obstacle_map_cell_classifier #(
  parameter int NUM_OBST = 16,
  parameter int MAP_ROWS = 512,
  parameter int MAP_COLS = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port
  input  logic                           cfg_wr_en,
  input  logic [omc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [omc_pkg::COORD_W-1:0]    cfg_wdata,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [omc_pkg::ENTRY_W-1:0]    entry_index,
  input  logic                           shape_kind,
  input  logic [omc_pkg::COORD_W-1:0]    center_row,
  input  logic [omc_pkg::COORD_W-1:0]    center_col,
  input  logic [omc_pkg::COORD_W-1:0]    radius,
  input  logic [omc_pkg::COORD_W-1:0]    side_rows,
  input  logic [omc_pkg::COORD_W-1:0]    side_cols,
  input  logic [omc_pkg::COORD_W-1:0]    point_row,
  input  logic [omc_pkg::COORD_W-1:0]    point_col,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [omc_pkg::CLASS_W-1:0]    cell_class
);

  import omc_pkg::*;

  localparam int AW = (NUM_OBST > 1) ? $clog2(NUM_OBST) : 1;
  localparam int NUM_SCAN = (NUM_OBST < (1 << ENTRY_W)) ? NUM_OBST : (1 << ENTRY_W);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SCAN - 1);
  localparam int ENT_W = $bits(obst_entry_t);
  localparam int SQ_W = 2 * COORD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  coord_t start_x;
  coord_t start_y;
  coord_t target_x;
  coord_t target_y;

  // Query context.
  coord_t             qry_row;
  coord_t             qry_col;
  logic               pend_scan;
  logic [CLASS_W-1:0] pend_class;
  logic               hit;

  // Table bookkeeping.
  logic [NUM_OBST-1:0] entry_valid;
  logic [AW-1:0]       scan_addr;

  // Scan pipeline.
  logic        v1, v2, v3;
  logic        ent_ok1;
  logic [ENT_W-1:0] rd_data;
  obst_entry_t ent1;
  coord_t      dr1, dc1;
  logic        rect1;
  logic        kind2, rect2;
  coord_t      dr2, dc2, rad2;
  logic        kind3, rect3;
  logic [SQ_W-1:0] sq_r3, sq_c3, rad_sq3;
  logic        cover3;

  // Handshake decode.
  logic in_acc;
  logic wr_ok;
  logic out_free;
  logic mem_wr;
  logic rd_en;
  obst_entry_t wr_entry;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_ok    = ((ENTRY_W+5)'(entry_index) < (ENTRY_W+5)'(NUM_OBST));
  assign mem_wr   = in_acc && (opcode == OP_WRITE) && wr_ok;
  assign rd_en    = (state == ST_SCAN);
  assign out_free = !out_valid || out_ready;

  assign wr_entry = '{kind: shape_kind, row: center_row, col: center_col,
                      rad: radius, srow: side_rows, scol: side_cols};

  // Obstacle table memory.
  omc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_OBST)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (AW'(entry_index)),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // Stage one: an entry never written reads as an empty rectangle.
  always_comb begin
    ent1  = ent_ok1 ? obst_entry_t'(rd_data) : '0;
    dr1   = abs_diff(qry_row, ent1.row);
    dc1   = abs_diff(qry_col, ent1.col);
    rect1 = ({dr1, 1'b0} < {1'b0, ent1.srow}) && ({dc1, 1'b0} < {1'b0, ent1.scol});
  end

  // Stage three: circle compare on the registered squares.
  assign cover3 = (kind3 == KIND_CIRCLE) ?
                  ((SQ_W+1)'(sq_r3) + (SQ_W+1)'(sq_c3) <= (SQ_W+1)'(rad_sq3)) :
                  rect3;

  // Scan pipeline data registers.
  always_ff @(posedge clk) begin
    kind2   <= ent1.kind;
    rect2   <= rect1;
    dr2     <= dr1;
    dc2     <= dc1;
    rad2    <= ent1.rad;
    kind3   <= kind2;
    rect3   <= rect2;
    sq_r3   <= SQ_W'(dr2) * SQ_W'(dr2);
    sq_c3   <= SQ_W'(dc2) * SQ_W'(dc2);
    rad_sq3 <= SQ_W'(rad2) * SQ_W'(rad2);
  end

  // Control state machine, configuration, table flags and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      start_x     <= START_X_RST;
      start_y     <= START_Y_RST;
      target_x    <= TARGET_X_RST;
      target_y    <= TARGET_Y_RST;
      entry_valid <= '0;
      scan_addr   <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      ent_ok1     <= 1'b0;
      hit         <= 1'b0;
      pend_scan   <= 1'b0;
      pend_class  <= CLS_FREE;
      qry_row     <= '0;
      qry_col     <= '0;
      out_valid   <= 1'b0;
      cell_class  <= CLS_FREE;
    end else begin
      // Configuration writes.
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_START_X:  start_x  <= cfg_wdata;
          REG_START_Y:  start_y  <= cfg_wdata;
          REG_TARGET_X: target_x <= cfg_wdata;
          REG_TARGET_Y: target_y <= cfg_wdata;
          default: ;
        endcase
      end

      // The output register fills from a finished query and empties when its
      // transaction is taken.
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Pipeline valid flags.
      v1      <= rd_en;
      ent_ok1 <= entry_valid[scan_addr];
      v2      <= v1;
      v3      <= v2;
      if (v3 && cover3) begin
        hit <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (mem_wr) begin
            entry_valid[AW'(entry_index)] <= 1'b1;
          end
          if (in_acc && (opcode == OP_QUERY)) begin
            qry_row   <= point_row;
            qry_col   <= point_col;
            hit       <= 1'b0;
            scan_addr <= '0;
            pend_scan <= 1'b0;
            if (({1'b0, point_row} >= (COORD_W+1)'(MAP_ROWS)) ||
                ({1'b0, point_col} >= (COORD_W+1)'(MAP_COLS))) begin
              pend_class <= CLS_OUTSIDE;
              state      <= ST_FINISH;
            end else if (in_marker(point_row, point_col, target_x, target_y)) begin
              pend_class <= CLS_TARGET;
              state      <= ST_FINISH;
            end else if (in_marker(point_row, point_col, start_x, start_y)) begin
              pend_class <= CLS_START;
              state      <= ST_FINISH;
            end else begin
              pend_scan <= 1'b1;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // One table entry is read per cycle.
          if (scan_addr == LAST_ADDR) begin
            state <= ST_DRAIN;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            cell_class <= pend_scan ? (hit ? CLS_BLOCKED : CLS_FREE) : pend_class;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // No new transaction is taken while table reads are in flight.
  `OMC_ASSERT_IMP(a_busy_no_accept, clk, rst, (v1 || v2 || v3), !in_ready)
  // A finished result waits while the output register is still occupied.
  `OMC_ASSERT_NXT(a_finish_waits, clk, rst,
                  ((state == ST_FINISH) && out_valid && !out_ready), (state == ST_FINISH))
  // Results carry a defined class code.
  `OMC_ASSERT_IMP(a_class_range, clk, rst, out_valid, (cell_class <= CLS_OUTSIDE))
  // A write transaction never starts a table scan.
  `OMC_ASSERT_NXT(a_write_stays_idle, clk, rst,
                  (in_acc && (opcode == OP_WRITE)), (state == ST_IDLE))

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Obstacle map cell classifier testbench
// Loads circle and rectangle obstacles and classifies grid points under
// several marker placements. Every classification is compared, in order, with
// a model of the table and markers that is kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
  import omc_pkg::*;

  localparam int NUM_OBST = 16;
  localparam int MAP_ROWS = 512;
  localparam int MAP_COLS = 512;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER = 60;
  localparam int MAX_REPORTS = 10;

  // One input transaction as offered on the input channel.
  typedef struct packed {
    logic               op;
    logic [ENTRY_W-1:0] slot;
    logic               kind;
    coord_t             crow;
    coord_t             ccol;
    coord_t             rad;
    coord_t             srow;
    coord_t             scol;
    coord_t             prow;
    coord_t             pcol;
  } cell_item_t;

  // A class still owed by the block, with the point that asked for it.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    coord_t             prow;
    coord_t             pcol;
  } owed_class_t;

  // Mirrors the obstacle table and the marker centres, and holds the classes
  // that the block has yet to return.
  class cell_map_tracker;
    obst_entry_t obstacles[NUM_OBST];
    coord_t      start_row, start_col, target_row, target_col;
    owed_class_t owed_classes[$];
    int          failures;
    int          reports;
    int          classified;

    function new();
      foreach (obstacles[i]) obstacles[i] = '0;
      start_row = START_X_RST;
      start_col = START_Y_RST;
      target_row = TARGET_X_RST;
      target_col = TARGET_Y_RST;
      failures = 0;
      reports = 0;
      classified = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, coord_t value);
      case (idx)
        REG_START_X:  start_row = value;
        REG_START_Y:  start_col = value;
        REG_TARGET_X: target_row = value;
        REG_TARGET_Y: target_col = value;
        default: ;
      endcase
    endfunction

    function int distance(coord_t a, coord_t b);
      return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Twice each offset must lie strictly below the matching full side.
    function bit in_box(coord_t pr, coord_t pc, coord_t cr, coord_t cc,
                        int side_r, int side_c);
      return (2 * distance(pr, cr) < side_r) && (2 * distance(pc, cc) < side_c);
    endfunction

    function bit obstacle_covers(obst_entry_t e, coord_t pr, coord_t pc);
      int dr, dc;
      dr = distance(pr, e.row);
      dc = distance(pc, e.col);
      if (e.kind == KIND_CIRCLE)
        return dr * dr + dc * dc <= int'(e.rad) * int'(e.rad);
      return in_box(pr, pc, e.row, e.col, int'(e.srow), int'(e.scol));
    endfunction

    // Off the map first, then the target square, the start square, and the
    // obstacles last.
    function logic [CLASS_W-1:0] classify_point(coord_t pr, coord_t pc);
      logic [CLASS_W-1:0] cls;
      if (pr >= MAP_ROWS || pc >= MAP_COLS) return CLS_OUTSIDE;
      if (in_box(pr, pc, target_row, target_col, MARK_SIDE, MARK_SIDE)) return CLS_TARGET;
      if (in_box(pr, pc, start_row, start_col, MARK_SIDE, MARK_SIDE)) return CLS_START;
      cls = CLS_FREE;
      foreach (obstacles[i])
        if (obstacle_covers(obstacles[i], pr, pc)) cls = CLS_BLOCKED;
      return cls;
    endfunction

    // Called for every accepted input transaction.
    function void note_item(cell_item_t it);
      owed_class_t owed;
      if (it.op == OP_WRITE) begin
        if (int'(it.slot) < NUM_OBST) begin
          obstacles[it.slot].kind = it.kind;
          obstacles[it.slot].row = it.crow;
          obstacles[it.slot].col = it.ccol;
          obstacles[it.slot].rad = it.rad;
          obstacles[it.slot].srow = it.srow;
          obstacles[it.slot].scol = it.scol;
        end
      end else begin
        owed.cls = classify_point(it.prow, it.pcol);
        owed.prow = it.prow;
        owed.pcol = it.pcol;
        owed_classes = {owed_classes, owed};
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_class(logic [CLASS_W-1:0] got);
      owed_class_t owed;
      classified++;
      if (owed_classes.size() == 0) begin
        failures++;
        if (reports < MAX_REPORTS)
          $display("Mismatch: class %0d returned with no query outstanding", got);
        reports++;
        return;
      end
      owed = owed_classes.pop_front();
      if (got !== owed.cls) begin
        failures++;
        if (reports < MAX_REPORTS)
          $display("Mismatch at point (%0d,%0d): expected class %0d, got %0d",
                   owed.prow, owed.pcol, owed.cls, got);
        reports++;
      end
    endfunction

    function int pending();
      return owed_classes.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_X;
  coord_t             cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               opcode = OP_WRITE;
  logic [ENTRY_W-1:0] entry_index = '0;
  logic               shape_kind = KIND_RECT;
  coord_t             center_row = '0;
  coord_t             center_col = '0;
  coord_t             radius = '0;
  coord_t             side_rows = '0;
  coord_t             side_cols = '0;
  coord_t             point_row = '0;
  coord_t             point_col = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CLASS_W-1:0] cell_class;

  cell_map_tracker tracker = new();
  int burst_left = 0;
  int cycle_count = 0;

  obstacle_map_cell_classifier #(
    .NUM_OBST(NUM_OBST),
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS)
  ) uut (.*);

  // Clock generation.
  initial begin
    forever #10 clk = ~clk;
  end

  // The run is cut short if it goes on far beyond its expected length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Watch both channels and hand every transaction to the tracker.
  always @(posedge clk) begin
    cell_item_t seen;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.op = opcode;
        seen.slot = entry_index;
        seen.kind = shape_kind;
        seen.crow = center_row;
        seen.ccol = center_col;
        seen.rad = radius;
        seen.srow = side_rows;
        seen.scol = side_cols;
        seen.prow = point_row;
        seen.pcol = point_col;
        tracker.note_item(seen);
      end
      if (out_valid && out_ready) tracker.check_class(cell_class);
    end
  end

  // Result side: runs of steady acceptance, random stalls and long stalls,
  // with one long hold-off early on so that the block backs up.
  initial begin
    int  mode, mode_left, stall_left;
    bit  held_off;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    held_off = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held_off && tracker.classified >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (stall_left == 0 && mode == 2 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(5, 60);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (mode == 1) begin
        out_ready <= ($urandom_range(0, 9) < 6);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every field random over its full width; callers then set what matters.
  function automatic cell_item_t scrambled_item();
    cell_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.slot = ENTRY_W'($urandom);
    it.kind = 1'($urandom_range(0, 1));
    it.crow = coord_t'($urandom);
    it.ccol = coord_t'($urandom);
    it.rad = coord_t'($urandom);
    it.srow = coord_t'($urandom);
    it.scol = coord_t'($urandom);
    it.prow = coord_t'($urandom);
    it.pcol = coord_t'($urandom);
    return it;
  endfunction

  function automatic cell_item_t query_at(int pr, int pc);
    cell_item_t it;
    it = scrambled_item();
    it.op = OP_QUERY;
    it.prow = coord_t'(pr);
    it.pcol = coord_t'(pc);
    return it;
  endfunction

  function automatic cell_item_t entry_at(int slot, logic kind, int cr, int cc,
                                          int rad, int sr, int sc);
    cell_item_t it;
    it = scrambled_item();
    it.op = OP_WRITE;
    it.slot = ENTRY_W'(slot);
    it.kind = kind;
    it.crow = coord_t'(cr);
    it.ccol = coord_t'(cc);
    it.rad = coord_t'(rad);
    it.srow = coord_t'(sr);
    it.scol = coord_t'(sc);
    return it;
  endfunction

  // A coordinate within spread of a centre, wrapping at the field width.
  function automatic coord_t near(coord_t centre, int spread);
    return coord_t'(int'(centre) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Table writes with mostly modest shapes, and queries aimed at the markers,
  // at stored obstacles, across the map and off it.
  function automatic cell_item_t random_item();
    cell_item_t  it;
    obst_entry_t e;
    int          pick, spread;
    it = scrambled_item();
    if ($urandom_range(0, 9) < 3) begin
      it.op = OP_WRITE;
      if ($urandom_range(0, 9) < 7) it.crow = coord_t'($urandom_range(0, MAP_ROWS - 1));
      if ($urandom_range(0, 9) < 7) it.ccol = coord_t'($urandom_range(0, MAP_COLS - 1));
      if ($urandom_range(0, 19) != 0) it.rad = coord_t'($urandom_range(0, 80));
      if ($urandom_range(0, 9) != 0) it.srow = coord_t'($urandom_range(0, 160));
      if ($urandom_range(0, 9) != 0) it.scol = coord_t'($urandom_range(0, 160));
    end else begin
      it.op = OP_QUERY;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        it.prow = near(tracker.target_row, 12);
        it.pcol = near(tracker.target_col, 12);
      end else if (pick < 30) begin
        it.prow = near(tracker.start_row, 12);
        it.pcol = near(tracker.start_col, 12);
      end else if (pick < 70) begin
        e = tracker.obstacles[$urandom_range(0, NUM_OBST - 1)];
        if (e.kind == KIND_CIRCLE) spread = int'(e.rad) + 2;
        else spread = ((e.srow > e.scol) ? int'(e.srow) : int'(e.scol)) / 2 + 2;
        if (spread > 300) spread = 300;
        it.prow = near(e.row, spread);
        it.pcol = near(e.col, spread);
      end else if (pick >= 80) begin
        it.prow = coord_t'($urandom_range(0, MAP_ROWS - 1));
        it.pcol = coord_t'($urandom_range(0, MAP_COLS - 1));
      end
    end
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then perhaps leave a gap.
  task automatic send_item(cell_item_t it);
    int roll;
    opcode <= it.op;
    entry_index <= it.slot;
    shape_kind <= it.kind;
    center_row <= it.crow;
    center_col <= it.ccol;
    radius <= it.rad;
    side_rows <= it.srow;
    side_cols <= it.scol;
    point_row <= it.prow;
    point_col <= it.pcol;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
      roll = $urandom_range(0, 99);
      if (roll >= 55) begin
        in_valid <= 1'b0;
        repeat (roll >= 92 ? $urandom_range(15, 60) : $urandom_range(1, 3)) @(posedge clk);
      end
    end
  endtask

  // Stop offering until every class owed has come back, then let the block
  // settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(logic [CFG_IDX_W-1:0] idx, coord_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.set_register(idx, value);
  endtask

  task automatic load_markers(coord_t srow, coord_t scol, coord_t trow, coord_t tcol);
    put_register(REG_START_X, srow);
    put_register(REG_START_Y, scol);
    put_register(REG_TARGET_X, trow);
    put_register(REG_TARGET_Y, tcol);
    cfg_wr_en <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    cell_item_t directed[$];
    coord_t     shared_row, shared_col;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Map edges and marker borders with the table still empty.
    directed = {directed, query_at(0, 0)};
    directed = {directed, query_at(MAP_ROWS, 0)};
    directed = {directed, query_at(0, MAP_COLS)};
    directed = {directed, query_at(1023, 1023)};
    directed = {directed, query_at(MAP_ROWS - 1, MAP_COLS - 1)};
    directed = {directed, query_at(492, 492)};
    directed = {directed, query_at(501, 483)};
    directed = {directed, query_at(502, 492)};
    directed = {directed, query_at(20, 20)};
    directed = {directed, query_at(11, 29)};
    directed = {directed, query_at(10, 20)};
    // A zero radius circle covers its centre only.
    directed = {directed, entry_at(0, KIND_CIRCLE, 100, 100, 0, 1023, 1023)};
    directed = {directed, query_at(100, 100)};
    directed = {directed, query_at(100, 101)};
    // A zero side rectangle covers nothing; a unit one covers its centre.
    directed = {directed, entry_at(1, KIND_RECT, 200, 200, 1023, 0, 0)};
    directed = {directed, query_at(200, 200)};
    directed = {directed, entry_at(2, KIND_RECT, 300, 300, 0, 1, 1)};
    directed = {directed, query_at(300, 300)};
    directed = {directed, query_at(300, 301)};
    // Huge shapes over the markers: the markers and the map edge still win.
    directed = {directed, entry_at(15, KIND_CIRCLE, 1023, 1023, 1023, 1023, 1023)};
    directed = {directed, entry_at(14, KIND_RECT, 20, 20, 0, 1023, 1023)};
    directed = {directed, query_at(MAP_ROWS - 1, MAP_COLS - 1)};
    directed = {directed, query_at(492, 492)};
    directed = {directed, query_at(20, 20)};
    directed = {directed, query_at(30, 30)};
    directed = {directed, query_at(600, 600)};
    directed = {directed, entry_at(15, KIND_RECT, 0, 0, 0, 0, 0)};
    directed = {directed, entry_at(14, KIND_RECT, 0, 0, 0, 0, 0)};
    foreach (directed[i]) send_item(directed[i]);

    // Random phases, each under its own marker placement.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        case (phase)
          1: load_markers('0, '0, '1, '1);
          2: load_markers(coord_t'(MAP_ROWS - 1), coord_t'(MAP_COLS - 1), '0, '0);
          3: begin
            shared_row = coord_t'($urandom_range(0, MAP_ROWS - 1));
            shared_col = coord_t'($urandom_range(0, MAP_COLS - 1));
            load_markers(shared_row, shared_col, shared_row, shared_col);
          end
          4: load_markers(coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom));
          default: load_markers(coord_t'($urandom_range(0, MAP_ROWS - 1)),
                                coord_t'($urandom_range(0, MAP_COLS - 1)),
                                coord_t'($urandom_range(0, MAP_ROWS - 1)),
                                coord_t'($urandom_range(0, MAP_COLS - 1)));
        endcase
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item());
        if (phase == 0 && n == ITEMS_PER_PHASE / 2) drain_results();
      end
    end

    drain_results();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
